// ----- hw/rtl/gzip_header_parser_crc_check_macros.svh -----
// Assertion macros used by the gzip header parser checker.
`ifndef GZIP_HEADER_PARSER_CRC_CHECK_MACROS_SVH
`define GZIP_HEADER_PARSER_CRC_CHECK_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GZHP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("gzip header parser: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define GZHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("gzip header parser: next-cycle check failed");

`endif

// ----- hw/rtl/gzhp_pkg.sv -----
// Package: codes, field widths and helper functions of the gzip header parser.
`timescale 1ns / 1ps
package gzhp_pkg;

	// parser phases
	localparam logic [3:0] PH_FIXED   = 4'd0;
	localparam logic [3:0] PH_XLEN_LO = 4'd1;
	localparam logic [3:0] PH_XLEN_HI = 4'd2;
	localparam logic [3:0] PH_EXTRA   = 4'd3;
	localparam logic [3:0] PH_NAME    = 4'd4;
	localparam logic [3:0] PH_COMMENT = 4'd5;
	localparam logic [3:0] PH_HCRC_LO = 4'd6;
	localparam logic [3:0] PH_HCRC_HI = 4'd7;
	localparam logic [3:0] PH_PAYLOAD = 4'd8;
	localparam logic [3:0] PH_ERROR   = 4'd9;

	// sections passed to next_section
	localparam logic [1:0] SEC_FIXED   = 2'd0;
	localparam logic [1:0] SEC_EXTRA   = 2'd1;
	localparam logic [1:0] SEC_NAME    = 2'd2;
	localparam logic [1:0] SEC_COMMENT = 2'd3;

	// result status codes
	localparam logic [1:0] ST_HEADER  = 2'd0;
	localparam logic [1:0] ST_DONE    = 2'd1;
	localparam logic [1:0] ST_ERROR   = 2'd2;
	localparam logic [1:0] ST_PAYLOAD = 2'd3;

	// error codes
	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_MAGIC  = 3'd1;
	localparam logic [2:0] ERR_METHOD = 3'd2;
	localparam logic [2:0] ERR_RSVD   = 3'd3;
	localparam logic [2:0] ERR_HCRC   = 3'd4;

	// fixed header byte positions and values
	localparam logic [3:0] POS_ID1   = 4'd0;
	localparam logic [3:0] POS_ID2   = 4'd1;
	localparam logic [3:0] POS_CM    = 4'd2;
	localparam logic [3:0] POS_FLG   = 4'd3;
	localparam logic [3:0] POS_MT0   = 4'd4;
	localparam logic [3:0] POS_MT3   = 4'd7;
	localparam logic [3:0] POS_OS    = 4'd9;
	localparam logic [7:0] ID1_VAL   = 8'd31;
	localparam logic [7:0] ID2_VAL   = 8'd139;
	localparam logic [7:0] CM_DEFL   = 8'd8;

	// FLG bits
	localparam int FL_FHCRC    = 1;
	localparam int FL_FEXTRA   = 2;
	localparam int FL_FNAME    = 3;
	localparam int FL_FCOMMENT = 4;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// stream packing
	localparam int TDATA_W = 56;
	localparam int TUSER_W = 4;

	// One byte of reflected CRC-32, eight shift steps.
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? (CRC_POLY ^ {1'b0, r[31:1]}) : {1'b0, r[31:1]};
		end
		return r;
	endfunction

	// Phase that follows the given section, from the captured flags.
	function automatic logic [3:0] next_section(input logic [1:0] sec, input logic [4:0] fl);
		logic [3:0] ph;
		if (sec < SEC_EXTRA && fl[FL_FEXTRA]) begin
			ph = PH_XLEN_LO;
		end else if (sec < SEC_NAME && fl[FL_FNAME]) begin
			ph = PH_NAME;
		end else if (sec < SEC_COMMENT && fl[FL_FCOMMENT]) begin
			ph = PH_COMMENT;
		end else if (fl[FL_FHCRC]) begin
			ph = PH_HCRC_LO;
		end else begin
			ph = PH_PAYLOAD;
		end
		return ph;
	endfunction

endpackage

// ----- hw/rtl/gzip_header_parser_crc_check.sv -----
// Top level: gzip member header parser with header CRC-16 check.
`timescale 1ns / 1ps
//
//  channel   direction  handshake           contents
//  s_*       in         s_tvalid/s_tready   one member byte, restart flag
//  m_*       out        m_tvalid/m_tready   one result per input byte
//  cfg_*     in         cfg_valid/cfg_ready expected OS byte
//
//  Cycles: one item per clock sustained while m_tready stays high; a byte's
//  result passes the input register, then the result register, on its way to m_*.
//  The per-byte CRC update and the phase logic sit between those two registers.
//  Reset: arst_n clears the parser to "expect first magic byte", CRC to all
//  ones and expected OS to zero. cfg_ready is always high.
//  Stalls: m_tready low holds the result; the input register still takes one
//  more item, then s_tready drops until the result moves.
//
module gzip_header_parser_crc_check (
	input  logic                          clk,
	input  logic                          arst_n,
	// config write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [7:0]                    cfg_data,   // expected_os
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,    // [7:0] data_byte
	input  logic [0:0]                    s_tuser,    // [0] start_member
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [2:0] error_code, [10:3] byte_out, [42:11] mod_time_out,
	// [47:43] flags_out, [48] os_mismatch, [55:49] zero
	output logic [gzhp_pkg::TDATA_W-1:0]  m_tdata,
	// [1:0] status, [2] name_char, [3] comment_char
	output logic [gzhp_pkg::TUSER_W-1:0]  m_tuser
);

	// configuration
	logic [7:0]  exp_os_q;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	// result register
	logic        valid_s2;
	logic [gzhp_pkg::TDATA_W-1:0] data_s2;
	logic [gzhp_pkg::TUSER_W-1:0] user_s2;

	// parser state
	logic [3:0]  phase_q;
	logic [3:0]  fpos_q;
	logic [15:0] extra_q;
	logic [31:0] crc_q;
	logic [4:0]  flags_q;
	logic [31:0] mtime_q;
	logic [7:0]  chk_lo_q;
	logic [2:0]  err_q;

	// state as seen by this byte (after a restart)
	logic [3:0]  cur_phase;
	logic [3:0]  cur_fpos;
	logic [15:0] cur_extra;
	logic [31:0] cur_crc;
	logic [4:0]  cur_flags;
	logic [31:0] cur_mtime;
	logic [7:0]  cur_chk;
	logic [2:0]  cur_err;

	// next state
	logic [3:0]  phase_n;
	logic [3:0]  fpos_n;
	logic [15:0] extra_n;
	logic [31:0] crc_n;
	logic [4:0]  flags_n;
	logic [31:0] mtime_n;
	logic [7:0]  chk_n;
	logic [2:0]  err_n;

	// result fields
	logic [1:0]  status;
	logic [2:0]  err_out;
	logic        name_c;
	logic        comm_c;
	logic [7:0]  echo;
	logic        osm;
	logic [15:0] hcrc_got;

	logic        adv;

	// advance the input register into the result register when the latter is free
	assign adv       = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tuser  = user_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_os_q <= 8'd0;
		end else if (cfg_valid) begin
			exp_os_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
		end
	end

	// restart drops the whole parse state before the byte is handled
	always_comb begin
		if (start_s1) begin
			cur_phase = gzhp_pkg::PH_FIXED;
			cur_fpos  = 4'd0;
			cur_extra = 16'd0;
			cur_crc   = gzhp_pkg::CRC_INIT;
			cur_flags = 5'd0;
			cur_mtime = 32'd0;
			cur_chk   = 8'd0;
			cur_err   = gzhp_pkg::ERR_NONE;
		end else begin
			cur_phase = phase_q;
			cur_fpos  = fpos_q;
			cur_extra = extra_q;
			cur_crc   = crc_q;
			cur_flags = flags_q;
			cur_mtime = mtime_q;
			cur_chk   = chk_lo_q;
			cur_err   = err_q;
		end
	end

	// per-byte parse step
	always_comb begin
		phase_n  = cur_phase;
		fpos_n   = cur_fpos;
		extra_n  = cur_extra;
		flags_n  = cur_flags;
		mtime_n  = cur_mtime;
		chk_n    = cur_chk;
		err_n    = cur_err;
		status   = gzhp_pkg::ST_HEADER;
		name_c   = 1'b0;
		comm_c   = 1'b0;
		echo     = 8'd0;
		osm      = 1'b0;
		hcrc_got = {byte_s1, cur_chk};

		// CRC covers every header byte up to the FHCRC field
		if (cur_phase <= gzhp_pkg::PH_COMMENT) begin
			crc_n = gzhp_pkg::crc_byte(cur_crc, byte_s1);
		end else begin
			crc_n = cur_crc;
		end

		unique case (cur_phase)
			gzhp_pkg::PH_FIXED: begin
				if (cur_fpos == gzhp_pkg::POS_ID1 && byte_s1 != gzhp_pkg::ID1_VAL) begin
					err_n   = gzhp_pkg::ERR_MAGIC;
					phase_n = gzhp_pkg::PH_ERROR;
				end else if (cur_fpos == gzhp_pkg::POS_ID2 &&
						byte_s1 != gzhp_pkg::ID2_VAL) begin
					err_n   = gzhp_pkg::ERR_MAGIC;
					phase_n = gzhp_pkg::PH_ERROR;
				end else if (cur_fpos == gzhp_pkg::POS_CM && byte_s1 != gzhp_pkg::CM_DEFL) begin
					err_n   = gzhp_pkg::ERR_METHOD;
					phase_n = gzhp_pkg::PH_ERROR;
				end else if (cur_fpos == gzhp_pkg::POS_FLG && byte_s1[7:5] != 3'd0) begin
					// flags are still captured on a reserved-bit error
					flags_n = byte_s1[4:0];
					err_n   = gzhp_pkg::ERR_RSVD;
					phase_n = gzhp_pkg::PH_ERROR;
				end else begin
					if (cur_fpos == gzhp_pkg::POS_FLG) begin
						flags_n = byte_s1[4:0];
					end
					// MTIME little-endian: byte k lands at bits 8k+7..8k
					if (cur_fpos >= gzhp_pkg::POS_MT0 && cur_fpos <= gzhp_pkg::POS_MT3) begin
						mtime_n = cur_mtime | ({24'd0, byte_s1} << {cur_fpos[1:0], 3'b000});
					end
					if (cur_fpos >= gzhp_pkg::POS_OS) begin
						osm     = (byte_s1 != exp_os_q);
						fpos_n  = 4'd0;
						phase_n = gzhp_pkg::next_section(gzhp_pkg::SEC_FIXED, cur_flags);
					end else begin
						fpos_n = cur_fpos + 4'd1;
					end
				end
			end
			gzhp_pkg::PH_XLEN_LO: begin
				extra_n = {8'd0, byte_s1};
				phase_n = gzhp_pkg::PH_XLEN_HI;
			end
			gzhp_pkg::PH_XLEN_HI: begin
				extra_n = {byte_s1, cur_extra[7:0]};
				if ({byte_s1, cur_extra[7:0]} == 16'd0) begin
					phase_n = gzhp_pkg::next_section(gzhp_pkg::SEC_EXTRA, cur_flags);
				end else begin
					phase_n = gzhp_pkg::PH_EXTRA;
				end
			end
			gzhp_pkg::PH_EXTRA: begin
				extra_n = cur_extra - 16'd1;
				if (cur_extra == 16'd1) begin
					phase_n = gzhp_pkg::next_section(gzhp_pkg::SEC_EXTRA, cur_flags);
				end
			end
			gzhp_pkg::PH_NAME: begin
				if (byte_s1 == 8'd0) begin
					phase_n = gzhp_pkg::next_section(gzhp_pkg::SEC_NAME, cur_flags);
				end else begin
					name_c = 1'b1;
					echo   = byte_s1;
				end
			end
			gzhp_pkg::PH_COMMENT: begin
				if (byte_s1 == 8'd0) begin
					phase_n = gzhp_pkg::next_section(gzhp_pkg::SEC_COMMENT, cur_flags);
				end else begin
					comm_c = 1'b1;
					echo   = byte_s1;
				end
			end
			gzhp_pkg::PH_HCRC_LO: begin
				chk_n   = byte_s1;
				phase_n = gzhp_pkg::PH_HCRC_HI;
			end
			gzhp_pkg::PH_HCRC_HI: begin
				// header check is the low half of the finished (inverted) CRC-32
				if (hcrc_got != ~cur_crc[15:0]) begin
					err_n   = gzhp_pkg::ERR_HCRC;
					phase_n = gzhp_pkg::PH_ERROR;
				end else begin
					phase_n = gzhp_pkg::PH_PAYLOAD;
				end
			end
			gzhp_pkg::PH_PAYLOAD: begin
				status = gzhp_pkg::ST_PAYLOAD;
				echo   = byte_s1;
			end
			default: begin
				phase_n = gzhp_pkg::PH_ERROR;
			end
		endcase
	end

	// status from the phase this byte leaves behind
	always_comb begin
		err_out = gzhp_pkg::ERR_NONE;
		if (phase_n == gzhp_pkg::PH_ERROR) begin
			err_out = err_n;
		end
	end

	// state update on every byte that moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= gzhp_pkg::PH_FIXED;
			fpos_q   <= 4'd0;
			extra_q  <= 16'd0;
			crc_q    <= gzhp_pkg::CRC_INIT;
			flags_q  <= 5'd0;
			mtime_q  <= 32'd0;
			chk_lo_q <= 8'd0;
			err_q    <= gzhp_pkg::ERR_NONE;
		end else if (adv) begin
			phase_q  <= phase_n;
			fpos_q   <= fpos_n;
			extra_q  <= extra_n;
			crc_q    <= crc_n;
			flags_q  <= flags_n;
			mtime_q  <= mtime_n;
			chk_lo_q <= chk_n;
			err_q    <= err_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (phase_n == gzhp_pkg::PH_ERROR) begin
				// error answers drop the byte and the char marks
				user_s2 <= {1'b0, 1'b0, gzhp_pkg::ST_ERROR};
				data_s2 <= {7'd0, osm, flags_n, mtime_n, 8'd0, err_out};
			end else if (phase_n == gzhp_pkg::PH_PAYLOAD &&
					status != gzhp_pkg::ST_PAYLOAD) begin
				user_s2 <= {comm_c, name_c, gzhp_pkg::ST_DONE};
				data_s2 <= {7'd0, osm, flags_n, mtime_n, echo, err_out};
			end else begin
				user_s2 <= {comm_c, name_c, status};
				data_s2 <= {7'd0, osm, flags_n, mtime_n, echo, err_out};
			end
		end
	end

endmodule

// ----- hw/rtl/gzhp_checker.sv -----
// Port-level checker for the gzip header parser, bound to the top level.
`timescale 1ns / 1ps
`include "gzip_header_parser_crc_check_macros.svh"

module gzhp_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [gzhp_pkg::TDATA_W-1:0]  m_tdata,
	input  logic [gzhp_pkg::TUSER_W-1:0]  m_tuser
);

	// a stalled result holds
	`GZHP_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// an error result carries a code and no byte or char marks
	`GZHP_ASSERT_NOW(a_err_clean, clk, arst_n, m_tvalid && m_tuser[1:0] == gzhp_pkg::ST_ERROR, m_tdata[2:0] != gzhp_pkg::ERR_NONE && m_tdata[10:3] == 8'd0 && m_tuser[3:2] == 2'b00)

	// any other result has no error code
	`GZHP_ASSERT_NOW(a_no_err, clk, arst_n, m_tvalid && m_tuser[1:0] != gzhp_pkg::ST_ERROR, m_tdata[2:0] == gzhp_pkg::ERR_NONE)

	// a byte is never both name and comment
	`GZHP_ASSERT_NOW(a_char_excl, clk, arst_n, m_tvalid, !(m_tuser[2] && m_tuser[3]))

endmodule

bind gzip_header_parser_crc_check gzhp_checker u_gzhp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
